// ===== rtl/gfmi_pkg.sv =====
package gfmi_pkg;

    localparam int DATA_W    = 64;
    localparam int DEG_W     = 7;
    localparam int STAT_W    = 2;
    localparam int CFG_IDX_W = 1;
    localparam int RED_W     = $clog2(DATA_W);

    localparam logic [CFG_IDX_W-1:0] CFG_FIELD_DEGREE      = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MODULUS_LOW_TERMS = 1'b1;

    localparam logic [DEG_W-1:0]  FIELD_DEGREE_RST = 7'd8;
    localparam logic [DATA_W-1:0] MODULUS_LOW_RST  = 64'd27;

    typedef enum logic
    {
        REQ_MUL = 1'b0,
        REQ_INV = 1'b1
    } req_t;

    typedef enum logic [STAT_W-1:0]
    {
        STATUS_OK     = 2'd0,
        STATUS_ZERO   = 2'd1,
        STATUS_NO_INV = 2'd2
    } status_t;

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_RED,
        ST_MUL,
        ST_INV,
        ST_FIN
    } state_t;

endpackage

// ===== rtl/gf2n_mul_inverse.sv =====
// GF(2^n) multiply / inverse unit, field polynomial x^n + modulus_low_terms.
// Channels: request (in_valid/in_ready: req_type, operand_a, operand_b),
// result (out_valid/out_ready: result_value, status) and a config write
// channel (cfg_valid/cfg_ready, cfg_index, cfg_data) that is always ready.
// One transaction in gives exactly one transaction out, in order.
// Both operands are first reduced one bit per cycle.
// A multiply then runs one bit of b per cycle, MSB first.
// An inverse runs a bit-serial extended Euclid: each cycle lowers the
// degree of one remainder by one. Inverse of zero skips the datapath.
// One request is in flight at a time; a new one is taken while the
// previous result still waits in the output register.
// If the receiver stalls, the result holds in the output register and the
// next finished result waits until the register is taken.
// Reset (rst_n low, asynchronous) empties the unit and loads n = 8,
// low terms 0x1B.
module gf2n_mul_inverse
    import gfmi_pkg::*;
#(
    parameter int MAX_WIDTH = 64
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 req_type,
    input  logic [DATA_W-1:0]    operand_a,
    input  logic [DATA_W-1:0]    operand_b,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [DATA_W-1:0]    result_value,
    output logic [STAT_W-1:0]    status,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]    cfg_data
);

    localparam int MW    = MAX_WIDTH;
    localparam int MFW   = MAX_WIDTH + 1;
    localparam int VW    = 2 * MAX_WIDTH + 1;
    localparam int IDX_W = $clog2(MAX_WIDTH);
    localparam int CNT_W = $clog2(MAX_WIDTH + 1);

    state_t              state_reg, state_next;
    logic [DEG_W-1:0]    fdeg_reg, fdeg_next;
    logic [DATA_W-1:0]   modlow_reg, modlow_next;
    req_t                req_reg, req_next;
    logic [RED_W-1:0]    red_cnt_reg, red_cnt_next;
    logic [IDX_W-1:0]    bit_idx_reg, bit_idx_next;
    logic [CNT_W-1:0]    dp_reg, dp_next;
    logic [CNT_W-1:0]    dq_reg, dq_next;
    logic                out_valid_reg, out_valid_next;

    logic [DATA_W-1:0]   opa_reg, opa_next;
    logic [DATA_W-1:0]   opb_reg, opb_next;
    logic [MW-1:0]       ra_reg, ra_next;
    logic [MW-1:0]       rb_reg, rb_next;
    logic [MW-1:0]       acc_reg, acc_next;
    logic [MFW-1:0]      pa_reg, pa_next;
    logic [MFW-1:0]      qa_reg, qa_next;
    logic [VW-1:0]       vp_reg, vp_next;
    logic [VW-1:0]       vq_reg, vq_next;
    logic [MW-1:0]       res_reg, res_next;
    status_t             res_stat_reg, res_stat_next;
    logic [DATA_W-1:0]   result_reg, result_next;
    logic [STAT_W-1:0]   status_reg, status_next;

    logic [CNT_W-1:0]    n_eff;
    logic [IDX_W-1:0]    n_m1;
    logic [MW-1:0]       mask;
    logic [MW-1:0]       low_m;
    logic [MFW-1:0]      mfull;
    logic [MW-1:0]       ra_step;
    logic [MW-1:0]       rb_step;
    logic [MW-1:0]       acc_step;

    // multiply by x modulo the field polynomial
    function automatic logic [MAX_WIDTH-1:0] xtime(
        input logic [MAX_WIDTH-1:0] r,
        input logic [IDX_W-1:0]     top,
        input logic [MAX_WIDTH-1:0] msk,
        input logic [MAX_WIDTH-1:0] lowp
    );
        logic [MAX_WIDTH-1:0] sh;
        sh = (r << 1) & msk;
        return r[top] ? (sh ^ lowp) : sh;
    endfunction

    always_comb
    begin
        if (fdeg_reg == '0)
        begin
            n_eff = CNT_W'(1);
        end
        else if (fdeg_reg > DEG_W'(MW))
        begin
            n_eff = CNT_W'(MW);
        end
        else
        begin
            n_eff = fdeg_reg[CNT_W-1:0];
        end
        n_m1 = IDX_W'(n_eff - CNT_W'(1));
        for (int i = 0; i < MW; i++)
        begin
            mask[i] = (CNT_W'(i) < n_eff);
        end
        low_m = modlow_reg[MW-1:0] & mask;
        mfull = {1'b0, low_m} | (MFW'(1) << n_eff);
    end

    assign ra_step  = xtime(ra_reg, n_m1, mask, low_m) ^ MW'(opa_reg[DATA_W-1]);
    assign rb_step  = xtime(rb_reg, n_m1, mask, low_m) ^ MW'(opb_reg[DATA_W-1]);
    assign acc_step = xtime(acc_reg, n_m1, mask, low_m) ^ (rb_reg[bit_idx_reg] ? ra_reg : '0);

    always_comb
    begin
        state_next     = state_reg;
        fdeg_next      = fdeg_reg;
        modlow_next    = modlow_reg;
        req_next       = req_reg;
        red_cnt_next   = red_cnt_reg;
        bit_idx_next   = bit_idx_reg;
        dp_next        = dp_reg;
        dq_next        = dq_reg;
        out_valid_next = out_valid_reg;
        opa_next       = opa_reg;
        opb_next       = opb_reg;
        ra_next        = ra_reg;
        rb_next        = rb_reg;
        acc_next       = acc_reg;
        pa_next        = pa_reg;
        qa_next        = qa_reg;
        vp_next        = vp_reg;
        vq_next        = vq_reg;
        res_next       = res_reg;
        res_stat_next  = res_stat_reg;
        result_next    = result_reg;
        status_next    = status_reg;

        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_FIELD_DEGREE:      fdeg_next   = cfg_data[DEG_W-1:0];
                CFG_MODULUS_LOW_TERMS: modlow_next = cfg_data;
            endcase
        end

        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    opa_next     = operand_a;
                    opb_next     = operand_b;
                    req_next     = req_t'(req_type);
                    ra_next      = '0;
                    rb_next      = '0;
                    red_cnt_next = '1;
                    if (req_t'(req_type) == REQ_INV && operand_a == '0)
                    begin
                        res_next      = '0;
                        res_stat_next = STATUS_ZERO;
                        state_next    = ST_FIN;
                    end
                    else
                    begin
                        state_next = ST_RED;
                    end
                end
            end
            ST_RED:
            begin
                ra_next      = ra_step;
                rb_next      = rb_step;
                opa_next     = opa_reg << 1;
                opb_next     = opb_reg << 1;
                red_cnt_next = red_cnt_reg - RED_W'(1);
                if (red_cnt_reg == '0)
                begin
                    if (req_reg == REQ_MUL)
                    begin
                        acc_next     = '0;
                        bit_idx_next = n_m1;
                        state_next   = ST_MUL;
                    end
                    else if (ra_step == '0)
                    begin
                        res_next      = '0;
                        res_stat_next = STATUS_NO_INV;
                        state_next    = ST_FIN;
                    end
                    else
                    begin
                        pa_next    = mfull;
                        qa_next    = {1'b0, ra_step};
                        dp_next    = CNT_W'(MW);
                        dq_next    = CNT_W'(MW);
                        vp_next    = '0;
                        vq_next    = VW'(1);
                        state_next = ST_INV;
                    end
                end
            end
            ST_MUL:
            begin
                acc_next     = acc_step;
                bit_idx_next = bit_idx_reg - IDX_W'(1);
                if (bit_idx_reg == '0)
                begin
                    res_next      = acc_step;
                    res_stat_next = STATUS_OK;
                    state_next    = ST_FIN;
                end
            end
            ST_INV:
            begin
                // pa/qa hold each remainder left-aligned to bit MW, dp/dq its degree bound;
                // vp/vq hold the matching coefficient times x^(MW - degree).
                priority if (dp_reg == '0 && pa_reg[MW])
                begin
                    res_next      = vp_reg[2*MW-1:MW] & mask;
                    res_stat_next = STATUS_OK;
                    state_next    = ST_FIN;
                end
                else if (dq_reg == '0 && qa_reg[MW])
                begin
                    res_next      = vq_reg[2*MW-1:MW] & mask;
                    res_stat_next = STATUS_OK;
                    state_next    = ST_FIN;
                end
                else if (dp_reg == '0 || dq_reg == '0)
                begin
                    res_next      = '0;
                    res_stat_next = STATUS_NO_INV;
                    state_next    = ST_FIN;
                end
                else if (!qa_reg[MW])
                begin
                    qa_next = qa_reg << 1;
                    vq_next = vq_reg << 1;
                    dq_next = dq_reg - CNT_W'(1);
                end
                else if (!pa_reg[MW])
                begin
                    pa_next = pa_reg << 1;
                    vp_next = vp_reg << 1;
                    dp_next = dp_reg - CNT_W'(1);
                end
                else if (dp_reg >= dq_reg)
                begin
                    pa_next = (pa_reg ^ qa_reg) << 1;
                    vp_next = (vp_reg ^ vq_reg) << 1;
                    dp_next = dp_reg - CNT_W'(1);
                end
                else
                begin
                    qa_next = (qa_reg ^ pa_reg) << 1;
                    vq_next = (vq_reg ^ vp_reg) << 1;
                    dq_next = dq_reg - CNT_W'(1);
                end
            end
            ST_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    result_next    = DATA_W'(res_reg);
                    status_next    = STAT_W'(res_stat_reg);
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fdeg_reg      <= FIELD_DEGREE_RST;
            modlow_reg    <= MODULUS_LOW_RST;
            req_reg       <= REQ_MUL;
            red_cnt_reg   <= '0;
            bit_idx_reg   <= '0;
            dp_reg        <= '0;
            dq_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fdeg_reg      <= fdeg_next;
            modlow_reg    <= modlow_next;
            req_reg       <= req_next;
            red_cnt_reg   <= red_cnt_next;
            bit_idx_reg   <= bit_idx_next;
            dp_reg        <= dp_next;
            dq_reg        <= dq_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        opa_reg      <= opa_next;
        opb_reg      <= opb_next;
        ra_reg       <= ra_next;
        rb_reg       <= rb_next;
        acc_reg      <= acc_next;
        pa_reg       <= pa_next;
        qa_reg       <= qa_next;
        vp_reg       <= vp_next;
        vq_reg       <= vq_next;
        res_reg      <= res_next;
        res_stat_reg <= res_stat_next;
        result_reg   <= result_next;
        status_reg   <= status_next;
    end

    assign in_ready     = (state_reg == ST_IDLE);
    assign cfg_ready    = 1'b1;
    assign out_valid    = out_valid_reg;
    assign result_value = result_reg;
    assign status       = status_reg;

    a_accept_starts_work: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> state_reg != ST_IDLE)
        else $error("request transaction did not start work");

    a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_FIN)
        else $error("result presented outside of finish state");

    a_error_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && status_reg != STAT_W'(STATUS_OK) |-> result_reg == '0)
        else $error("error result carries nonzero value");

    a_gcd_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_INV |-> (pa_reg != '0) || (qa_reg != '0))
        else $error("both remainders zero during inverse");

    a_degree_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_INV |-> dp_reg <= CNT_W'(MW) && dq_reg <= CNT_W'(MW))
        else $error("remainder degree bound out of range");

endmodule
